// ----- design/pef_pkg.sv -----
// Package for the Prewitt edge filter: field widths, register indexes and
// the gradient clamp used by the filter.
// No dependencies.
package pef_pkg;

   localparam int PIX_W        = 8;
   localparam int CFG_W        = 13;
   localparam int ROW_W        = 13;
   localparam int IDX_W        = 2;
   localparam int SUM_W        = PIX_W + 2;
   localparam int RSP_W        = 3 * PIX_W;
   localparam int WIDTH_RESET  = 640;
   localparam int HEIGHT_LIMIT = 4096;

   localparam logic [ROW_W-1:0] HEIGHT_RESET = ROW_W'(480);
   localparam logic [ROW_W-1:0] HEIGHT_MAX   = ROW_W'(HEIGHT_LIMIT);

   localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH  = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT = IDX_W'(1);

   // Which neighbors of the 3x3 window lie inside the image.
   typedef struct packed {
      logic top;
      logic bot;
      logic left;
      logic right;
   } win_mask_type;

   // What travels with a word from the position counters to the output.
   typedef struct packed {
      win_mask_type mask;
      logic         eor;
      logic         eof;
   } res_tag_type;

   // Clamps a two's complement difference of two column or row sums to 0..255.
   function automatic logic [PIX_W-1:0] clamp_pix(input logic [SUM_W:0] diff);
      logic [PIX_W-1:0] res;
      if (diff[SUM_W]) begin
         res = '0;
      end else if (diff[SUM_W-1:PIX_W] != '0) begin
         res = '1;
      end else begin
         res = diff[PIX_W-1:0];
      end
      return res;
   endfunction

endpackage

// ----- design/prewitt_edge_filter.sv -----
// Prewitt edge filter, top level: line memory, 3x3 window and gradient stage.
// Depends on pef_pkg.
//
// Grey pixels enter in raster order, one word per clock cycle sustained while
// the result side takes its words, and a result passes through the stage 1,
// window and output registers after the word completing its window is taken;
// a stall on the result side holds the whole pipeline, so the input is ready
// exactly when the output register is empty or being taken. The pace is set
// by the line memory, which holds the two previous rows of one column in a
// single entry and is read on acceptance and written back from stage 1;
// when the image is one pixel wide the write-back is forwarded into the next
// read of the same entry. The result for pixel (r-1, c-1) comes out when
// pixel (r, c) is taken, so after the last row the host sends one row plus
// one pixel of pad words (tuser set) to drain the frame; a pad word inside
// the image counts as a black pixel. Neighbors outside the image count as
// zero, each gradient is clamped to 0..255 and edge_res is the larger one.
// Writing image_width or image_height restarts the frame; widths of zero
// count as one and widths above MAX_WIDTH as MAX_WIDTH, heights likewise
// within 1..4096. The line memory is not cleared after reset and needs no
// clearing pass: an entry that was never written only meets neighbors
// outside the image, which are masked out.
module prewitt_edge_filter #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [pef_pkg::PIX_W-1:0]    req_tdata,   // pixel
   input  logic                         req_tuser,   // pad
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [pef_pkg::RSP_W-1:0]    rsp_tdata,   // edge_res, grad_horiz, grad_vert
   output logic                         rsp_tlast,   // end_of_row
   output logic                         rsp_tuser,   // end_of_frame
   input  logic                         csr_we,
   input  logic [pef_pkg::IDX_W-1:0]    csr_index,
   input  logic [pef_pkg::CFG_W-1:0]    csr_wdata
);
   import pef_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WIDTH_RESET_EFF = (WIDTH_RESET > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RESET;
   localparam logic [COL_W-1:0] COL_LAST_MAX   = COL_W'(MAX_WIDTH - 1);
   localparam logic [COL_W-1:0] COL_LAST_RESET = COL_W'(WIDTH_RESET_EFF - 1);

   // Configuration, held as the last column index and the row count.
   logic [COL_W-1:0] col_last_ff, col_last_in;
   logic [ROW_W-1:0] height_ff, height_in;
   logic             cfg_width_wr, cfg_height_wr, cfg_restart;

   // Position of the next word.
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;

   // Pipeline control.
   logic en, accept;

   // Stage 0 decode.
   logic             col_first, col_end;
   logic             row_ge1, row_ge2, row_ge3, row_lt_h, row_le_h;
   logic             case_row_end, case_inner;
   logic [PIX_W-1:0] pix_in;
   res_tag_type      tag_in;

   // Stage 1: memory read data and the word that asked for it.
   logic                 s1_valid_ff;
   logic                 s1_emit_ff;
   logic [COL_W-1:0]     s1_col_ff;
   logic [PIX_W-1:0]     s1_pix_ff;
   res_tag_type          s1_tag_ff;
   logic [2*PIX_W-1:0]   rd_ff;
   logic                 fwd_hit_ff;
   logic [2*PIX_W-1:0]   fwd_data_ff;
   logic [2*PIX_W-1:0]   line_rd, wr_data;
   logic [PIX_W-1:0]     up_old, mid_old;

   // Each entry holds {upper row, middle row} of one column.
   logic [2*PIX_W-1:0]   line_mem [MAX_WIDTH];

   // Window [row top/mid/bot][column left/center/right], after the push.
   logic [PIX_W-1:0]     win_ff [3][3];

   // Stage 2: gradients of the word whose push completed the window.
   logic                 s2_valid_ff;
   res_tag_type          s2_tag_ff;
   logic [PIX_W-1:0]     elem [3][3];
   logic [2:0]           row_ok, col_ok;
   logic [SUM_W-1:0]     sum_left, sum_right, sum_top, sum_bot;
   logic [PIX_W-1:0]     grad_h, grad_v, edge_val;

   // Output register.
   logic                 rsp_valid_ff;
   logic [PIX_W-1:0]     edge_ff, grad_h_ff, grad_v_ff;
   logic                 eor_ff, eof_ff;

   // ---------------------------------------------------------------------
   // Configuration writes
   // ---------------------------------------------------------------------
   assign cfg_width_wr  = csr_we && (csr_index == REG_IMAGE_WIDTH);
   assign cfg_height_wr = csr_we && (csr_index == REG_IMAGE_HEIGHT);
   assign cfg_restart   = cfg_width_wr || cfg_height_wr;

   always_comb begin
      if (csr_wdata == '0) begin
         col_last_in = '0;
      end else if (32'(csr_wdata) > MAX_WIDTH) begin
         col_last_in = COL_LAST_MAX;
      end else begin
         col_last_in = COL_W'(CFG_W'(csr_wdata - CFG_W'(1)));
      end

      if (csr_wdata == '0) begin
         height_in = ROW_W'(1);
      end else if (ROW_W'(csr_wdata) > HEIGHT_MAX) begin
         height_in = HEIGHT_MAX;
      end else begin
         height_in = ROW_W'(csr_wdata);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_last_ff <= COL_LAST_RESET;
         height_ff   <= HEIGHT_RESET;
      end else begin
         if (cfg_width_wr) begin
            col_last_ff <= col_last_in;
         end
         if (cfg_height_wr) begin
            height_ff <= height_in;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: every stage moves when the output register can move.
   // ---------------------------------------------------------------------
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;
   assign accept     = req_tvalid && en;

   // ---------------------------------------------------------------------
   // Stage 0: position decode. A word at column zero, row two or later,
   // closes the previous row (center two rows up, last column); any other word
   // past column zero in rows 1..height has the center one row up, one column left.
   // ---------------------------------------------------------------------
   always_comb begin
      col_first = (col_ff == '0);
      col_end   = (col_ff == col_last_ff);
      row_ge1   = (row_ff != '0);
      row_ge2   = (row_ff >= ROW_W'(2));
      row_ge3   = (row_ff >= ROW_W'(3));
      row_lt_h  = (row_ff < height_ff);
      row_le_h  = (row_ff <= height_ff);

      case_row_end = col_first && row_ge2;
      case_inner   = !col_first && row_ge1 && row_le_h;

      // Pads and drain rows push black pixels.
      pix_in = (req_tuser || !row_lt_h) ? '0 : req_tdata;

      if (case_row_end) begin
         tag_in.mask.top   = row_ge3;
         tag_in.mask.bot   = row_le_h;
         tag_in.mask.left  = (col_last_ff != '0);
         tag_in.mask.right = 1'b0;
         tag_in.eor        = 1'b1;
         tag_in.eof        = !row_le_h;
      end else begin
         tag_in.mask.top   = row_ge2;
         tag_in.mask.bot   = row_lt_h;
         tag_in.mask.left  = (col_ff[COL_W-1:1] != '0);
         tag_in.mask.right = 1'b1;
         tag_in.eor        = 1'b0;
         tag_in.eof        = 1'b0;
      end

      // The word on the row after the drain row ends the frame.
      if (!row_le_h) begin
         col_in = '0;
         row_in = '0;
      end else if (col_end) begin
         col_in = '0;
         row_in = ROW_W'(row_ff + ROW_W'(1));
      end else begin
         col_in = COL_W'(col_ff + COL_W'(1));
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cfg_restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------------
   // Line memory: read on acceptance, written back by stage 1.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (en) begin
         rd_ff <= line_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (en && s1_valid_ff) begin
         line_mem[s1_col_ff] <= wr_data;
      end
   end

   // A write-back meets a read of the same entry at one edge in images one
   // pixel wide and between frames; the written data replaces the stale read.
   always_ff @(posedge clock) begin
      if (en) begin
         fwd_hit_ff  <= s1_valid_ff && (s1_col_ff == col_ff);
         fwd_data_ff <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_emit_ff <= case_row_end || case_inner;
         s1_col_ff  <= col_ff;
         s1_pix_ff  <= pix_in;
         s1_tag_ff  <= tag_in;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: shift the window and push the new column.
   // ---------------------------------------------------------------------
   assign line_rd = fwd_hit_ff ? fwd_data_ff : rd_ff;
   assign up_old  = line_rd[2*PIX_W-1:PIX_W];
   assign mid_old = line_rd[PIX_W-1:0];
   assign wr_data = {mid_old, s1_pix_ff};

   always_ff @(posedge clock) begin
      if (reset || cfg_restart) begin
         for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
               win_ff[i][j] <= '0;
            end
         end
      end else if (en && s1_valid_ff) begin
         for (int i = 0; i < 3; i++) begin
            win_ff[i][0] <= win_ff[i][1];
            win_ff[i][1] <= win_ff[i][2];
         end
         win_ff[0][2] <= up_old;
         win_ff[1][2] <= mid_old;
         win_ff[2][2] <= s1_pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (en) begin
         s2_valid_ff <= s1_valid_ff && s1_emit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s2_tag_ff <= s1_tag_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: masked kernel sums, clamp and maximum.
   // ---------------------------------------------------------------------
   assign row_ok = {s2_tag_ff.mask.bot, 1'b1, s2_tag_ff.mask.top};
   assign col_ok = {s2_tag_ff.mask.right, 1'b1, s2_tag_ff.mask.left};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            elem[i][j] = (row_ok[i] && col_ok[j]) ? win_ff[i][j] : '0;
         end
      end
      sum_left  = SUM_W'(elem[0][0]) + SUM_W'(elem[1][0]) + SUM_W'(elem[2][0]);
      sum_right = SUM_W'(elem[0][2]) + SUM_W'(elem[1][2]) + SUM_W'(elem[2][2]);
      sum_top   = SUM_W'(elem[0][0]) + SUM_W'(elem[0][1]) + SUM_W'(elem[0][2]);
      sum_bot   = SUM_W'(elem[2][0]) + SUM_W'(elem[2][1]) + SUM_W'(elem[2][2]);
      grad_h    = clamp_pix({1'b0, sum_right} - {1'b0, sum_left});
      grad_v    = clamp_pix({1'b0, sum_top} - {1'b0, sum_bot});
      edge_val  = (grad_h > grad_v) ? grad_h : grad_v;
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         edge_ff   <= edge_val;
         grad_h_ff <= grad_h;
         grad_v_ff <= grad_v;
         eor_ff    <= s2_tag_ff.eor;
         eof_ff    <= s2_tag_ff.eof;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {grad_v_ff, grad_h_ff, edge_ff};
   assign rsp_tlast  = eor_ff;
   assign rsp_tuser  = eof_ff;

endmodule

// ----- design/pef_checker.sv -----
// Port checker for the Prewitt edge filter, bound to the top level.
// Depends on pef_pkg and prewitt_edge_filter.
module pef_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [pef_pkg::RSP_W-1:0]    rsp_tdata,
   input logic                         rsp_tlast,
   input logic                         rsp_tuser
);
   import pef_pkg::*;

   logic [PIX_W-1:0] edge_w, gh_w, gv_w;

   assign edge_w = rsp_tdata[PIX_W-1:0];
   assign gh_w   = rsp_tdata[2*PIX_W-1:PIX_W];
   assign gv_w   = rsp_tdata[3*PIX_W-1:2*PIX_W];

   // A stalled result word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // The last pixel of a frame is also the last pixel of its row.
   a_eof_eor: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast)
      else $error("end of frame without end of row");

   // The edge value is the larger of the two gradients.
   a_edge_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (edge_w == gh_w || edge_w == gv_w) && edge_w >= gh_w && edge_w >= gv_w)
      else $error("edge value is not the gradient maximum");

   // An empty output register never blocks the input side.
   a_ready_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output register");

endmodule

bind prewitt_edge_filter pef_checker u_pef_checker (.*);

// ----- bench/pef_edge_checker.sv -----
// Scoreboard for the Prewitt edge filter: watches the pixel, result and register
// ports, predicts each edge word from its own copy of the filter state and
// compares the words field by field. Depends on pef_pkg.
module pef_edge_checker #(
   parameter int MAX_WIDTH = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [pef_pkg::PIX_W-1:0] req_tdata,   // pixel
   input  logic                      req_tuser,   // pad
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [pef_pkg::RSP_W-1:0] rsp_tdata,   // edge_res, grad_horiz, grad_vert
   input  logic                      rsp_tlast,   // end_of_row
   input  logic                      rsp_tuser,   // end_of_frame
   input  logic                      csr_we,
   input  logic [pef_pkg::IDX_W-1:0] csr_index,
   input  logic [pef_pkg::CFG_W-1:0] csr_wdata,
   output int                        error_count,
   output int                        pending_words,
   output int                        checked_words
);
   timeunit 1ns;
   timeprecision 1ps;
   import pef_pkg::*;

   typedef struct packed {
      logic [PIX_W-1:0] edge_res;
      logic [PIX_W-1:0] grad_horiz;
      logic [PIX_W-1:0] grad_vert;
      logic             eor;
      logic             eof;
   } edge_word_type;

   localparam int PRINT_CAP = 40;

   logic [CFG_W-1:0] width_reg;
   logic [CFG_W-1:0] height_reg;
   logic [PIX_W-1:0] upper_line [MAX_WIDTH];
   logic [PIX_W-1:0] middle_line [MAX_WIDTH];
   logic [PIX_W-1:0] win [3][3];   // [top/mid/bottom][left/center/right]
   int unsigned      col_pos;
   int unsigned      row_pos;
   edge_word_type    expected_edges [$];

   function automatic int unsigned eff_size(input logic [CFG_W-1:0] val,
                                            input int unsigned limit);
      if (val == '0) return 1;
      if (32'(val) > limit) return limit;
      return 32'(val);
   endfunction

   function automatic logic [PIX_W-1:0] clip_byte(input int sum);
      if (sum < 0) return '0;
      if (sum > 255) return '1;
      return PIX_W'(sum);
   endfunction

   task automatic restart_frame();
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            win[i][j] = '0;
         end
      end
      col_pos = 0;
      row_pos = 0;
   endtask

   task automatic flag_mismatch(input string msg);
      if (error_count < PRINT_CAP) begin
         $display("[%0t] MISMATCH: %s", $time, msg);
      end
      error_count++;
   endtask

   // Advances the window by one pixel word and queues the edge word it completes.
   task automatic predict_pixel(input logic [PIX_W-1:0] pix, input logic pad);
      int unsigned w, h, r, c;
      logic [PIX_W-1:0] v;
      int nb [3][3];
      bit emit, top_ok, bot_ok, left_ok, row_ok;
      int gh, gv;
      edge_word_type want;
      w = eff_size(width_reg, MAX_WIDTH);
      h = eff_size(height_reg, HEIGHT_LIMIT);
      r = row_pos;
      c = col_pos;
      v = pad ? '0 : pix;
      emit = 1'b0;
      want = '0;
      if (r >= h) v = '0;
      if (c >= w) c = w - 1;
      // The first word of a row closes the last pixel of the row two back.
      if (c == 0 && r >= 2) begin
         emit = 1'b1;
         top_ok = (r >= 3);
         bot_ok = (r <= h);
         left_ok = (w >= 2);
         for (int i = 0; i < 3; i++) begin
            row_ok = (i == 0) ? top_ok : ((i == 2) ? bot_ok : 1'b1);
            nb[i][0] = (row_ok && left_ok) ? int'(win[i][1]) : 0;
            nb[i][1] = row_ok ? int'(win[i][2]) : 0;
            nb[i][2] = 0;
         end
         want.eor = 1'b1;
         want.eof = (r == h + 1);
      end
      for (int i = 0; i < 3; i++) begin
         win[i][0] = win[i][1];
         win[i][1] = win[i][2];
      end
      win[0][2] = upper_line[c];
      win[1][2] = middle_line[c];
      win[2][2] = v;
      upper_line[c] = middle_line[c];
      middle_line[c] = v;
      if (c >= 1 && r >= 1 && r <= h) begin
         emit = 1'b1;
         top_ok = (r >= 2);
         bot_ok = (r < h);
         left_ok = (c >= 2);
         for (int i = 0; i < 3; i++) begin
            row_ok = (i == 0) ? top_ok : ((i == 2) ? bot_ok : 1'b1);
            for (int j = 0; j < 3; j++) begin
               nb[i][j] = (row_ok && (j != 0 || left_ok)) ? int'(win[i][j]) : 0;
            end
         end
         want.eor = 1'b0;
         want.eof = 1'b0;
      end
      c++;
      if (c >= w) begin
         c = 0;
         r++;
      end
      if (row_pos >= h + 1) begin
         c = 0;
         r = 0;
      end
      col_pos = c;
      row_pos = r;
      if (emit) begin
         gh = 0;
         gv = 0;
         for (int i = 0; i < 3; i++) begin
            gh += nb[i][2] - nb[i][0];
            gv += nb[0][i] - nb[2][i];
         end
         want.grad_horiz = clip_byte(gh);
         want.grad_vert = clip_byte(gv);
         want.edge_res = (want.grad_horiz > want.grad_vert) ? want.grad_horiz
                                                             : want.grad_vert;
         expected_edges.push_back(want);
      end
   endtask

   task automatic check_result();
      edge_word_type want;
      logic [PIX_W-1:0] got_edge, got_h, got_v;
      if (expected_edges.size() == 0) begin
         flag_mismatch($sformatf("result word %h with nothing expected", rsp_tdata));
         return;
      end
      want = expected_edges.pop_front();
      checked_words++;
      got_edge = rsp_tdata[PIX_W-1:0];
      got_h = rsp_tdata[2*PIX_W-1:PIX_W];
      got_v = rsp_tdata[3*PIX_W-1:2*PIX_W];
      if (got_edge !== want.edge_res)
         flag_mismatch($sformatf("word %0d edge_res %0d, expected %0d",
                                 checked_words, got_edge, want.edge_res));
      if (got_h !== want.grad_horiz)
         flag_mismatch($sformatf("word %0d grad_horiz %0d, expected %0d",
                                 checked_words, got_h, want.grad_horiz));
      if (got_v !== want.grad_vert)
         flag_mismatch($sformatf("word %0d grad_vert %0d, expected %0d",
                                 checked_words, got_v, want.grad_vert));
      if (rsp_tlast !== want.eor)
         flag_mismatch($sformatf("word %0d end_of_row %b, expected %b",
                                 checked_words, rsp_tlast, want.eor));
      if (rsp_tuser !== want.eof)
         flag_mismatch($sformatf("word %0d end_of_frame %b, expected %b",
                                 checked_words, rsp_tuser, want.eof));
   endtask

   initial begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         upper_line[i] = '0;
         middle_line[i] = '0;
      end
      error_count = 0;
      pending_words = 0;
      checked_words = 0;
      width_reg = CFG_W'(WIDTH_RESET);
      height_reg = HEIGHT_RESET;
      restart_frame();
   end

   // Sampled at the falling edge, where every port holds the value that the
   // next rising edge will act on.
   always @(negedge clock) begin
      if (reset) begin
         width_reg = CFG_W'(WIDTH_RESET);
         height_reg = HEIGHT_RESET;
         restart_frame();
         expected_edges.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IMAGE_WIDTH: begin
                  width_reg = csr_wdata;
                  restart_frame();
               end
               REG_IMAGE_HEIGHT: begin
                  height_reg = csr_wdata;
                  restart_frame();
               end
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_pixel(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_result();
      end
      pending_words = expected_edges.size();
   end

endmodule

// ----- bench/tb_top.sv -----
// Top of the Prewitt edge filter bench: clock, reset, pixel and register
// stimulus, result back-pressure and the verdict.
// Depends on pef_pkg, prewitt_edge_filter and pef_edge_checker.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import pef_pkg::*;

   localparam int LINE_MAX   = 4096;
   localparam int RAND_WORDS = 580;
   localparam int CALM_WORDS = 200;       // closing stretch without idling
   localparam int LONG_HOLD  = 80;        // cycles the result side holds off once
   localparam int SETTLE     = 8;         // quiet cycles after the last predicted result
   localparam int WHOLE      = 1 << 30;   // no cut: send the complete frame
   localparam int WIDE_CUT   = 24;        // words sent into the oversize-width image
   localparam int TALL_CUT   = 40;        // words sent into the oversize-height image
   localparam int DRAIN_MAX  = 20000;

   // The two indexes above the register list; writes there must change nothing.
   localparam logic [IDX_W-1:0] REG_SPARE_LO = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_SPARE_HI = IDX_W'(3);

   // A 3x3 image with strong edges in both directions, then its four drain
   // words. Bit 8 is the pad flag. The pad inside the image carries 255 that
   // must be read as black, and one drain word carries a pixel to be ignored.
   localparam logic [PIX_W:0] CORNER_WORDS [13] = '{
      9'h0FF, 9'h0FF, 9'h0FF,
      9'h000, 9'h1FF, 9'h0FF,
      9'h000, 9'h000, 9'h0FF,
      9'h1FF, 9'h0FF, 9'h100, 9'h1AA
   };

   logic              clock;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [PIX_W-1:0]  req_tdata;
   logic              req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tuser;
   logic              csr_we;
   logic [IDX_W-1:0]  csr_index;
   logic [CFG_W-1:0]  csr_wdata;

   int error_count;
   int pending_words;
   int checked_words;

   bit          src_idle_on = 1'b1;
   bit          sink_idle_on = 1'b1;
   bit          hold_req = 1'b0;
   int unsigned width_now = WIDTH_RESET;
   int unsigned height_now = 480;
   int          words_sent = 0;
   int          frames_sent = 0;
   int          writes_done = 0;

   prewitt_edge_filter #(.MAX_WIDTH(LINE_MAX)) dut (.*);

   pef_edge_checker #(.MAX_WIDTH(LINE_MAX)) scoreboard (.*);

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Result side. Mostly ready, with random stall bursts while sink_idle_on is
   // set, and one long hold-off on request so that the filter backs up and
   // stops taking pixels while the sender keeps offering them.
   initial begin : result_sink
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req = 1'b0;
         end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Mostly random noise, with a good share of full black and full white so
   // that both clamps are reached often.
   function automatic logic [PIX_W-1:0] pick_pixel();
      case ($urandom_range(0, 9))
         0, 1: return '0;
         2, 3: return '1;
         default: return PIX_W'($urandom);
      endcase
   endfunction

   // Offers one word and returns at the rising edge that takes it. The ready
   // line is looked at on the falling edge, where it already holds the value
   // that the coming rising edge sees.
   task automatic send_word(input logic [PIX_W-1:0] pix, input logic pad);
      bit took;
      if (src_idle_on && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= pad;
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      words_sent++;
   endtask

   // Stops offering words until every predicted result has been taken, then
   // lets the SETTLE wait pass for words that close no window yet.
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_words != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Register writes are only made with the filter empty.
   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      settle();
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      writes_done++;
   endtask

   // Writes both size registers and keeps the size that the filter will use,
   // with zero read as one and oversize values cut to the limits.
   task automatic set_image(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
      write_reg(REG_IMAGE_WIDTH, w_raw);
      write_reg(REG_IMAGE_HEIGHT, h_raw);
      width_now = (w_raw == '0) ? 1 : ((w_raw > LINE_MAX) ? LINE_MAX : w_raw);
      height_now = (h_raw == '0) ? 1 : ((h_raw > HEIGHT_LIMIT) ? HEIGHT_LIMIT : h_raw);
   endtask

   // One frame of the current size followed by its row-plus-one drain words,
   // or only its first cut words. Now and then a pad lands inside the image
   // and a real pixel lands in the drain.
   task automatic send_frame(input int cut);
      int area, total;
      area = width_now * height_now;
      total = area + width_now + 1;
      for (int k = 0; k < total && k < cut; k++) begin
         if (k < area) begin
            send_word(pick_pixel(), $urandom_range(0, 19) == 0);
         end else begin
            send_word(PIX_W'($urandom), $urandom_range(0, 7) != 0);
         end
      end
      if (cut >= total) frames_sent++;
   endtask

   initial begin : stimulus
      int rand_start, n_frames, total, w_raw, h_raw, k;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= 1'b0;
      csr_we <= 1'b0;
      csr_index <= REG_IMAGE_WIDTH;
      csr_wdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset size is 640 x 480: run just past the first row so that the first
      // results of the reset geometry come out, then leave the frame unfinished.
      send_frame(WIDTH_RESET + 20);

      // Directed part: a hand-made 3x3 frame, then a single-pixel image from
      // zero register values, then a 2x2 image interrupted by writes to the
      // unused indexes, which must leave the position alone.
      set_image(13'd3, 13'd3);
      foreach (CORNER_WORDS[i]) send_word(CORNER_WORDS[i][PIX_W-1:0], CORNER_WORDS[i][PIX_W]);
      frames_sent++;
      set_image('0, '0);
      send_word(8'hFF, 1'b0);
      send_word(8'h00, 1'b1);
      send_word(8'hAA, 1'b0);
      frames_sent++;
      set_image(13'd2, 13'd2);
      send_frame(3);
      write_reg(REG_SPARE_LO, CFG_W'($urandom));
      write_reg(REG_SPARE_HI, '1);
      send_frame(WHOLE);

      // Extremes of the registers, each left unfinished after a few words: an
      // oversize width cut to the line length, where no result may come out
      // this early, and an oversize height on a narrow image.
      set_image('1, 13'd1);
      send_frame(WIDE_CUT);
      set_image(13'd2, '1);
      send_frame(TALL_CUT);

      // The long hold-off: the sender offers words back to back while the
      // result side is held, so the filter fills up and stalls its input.
      set_image(13'd16, 13'd6);
      src_idle_on = 1'b0;
      hold_req = 1'b1;
      send_frame(WHOLE);

      // Random part: small images of random shape, mostly complete frames
      // back to back, some cut short and restarted by the next size write.
      rand_start = words_sent;
      while (words_sent - rand_start < RAND_WORDS) begin
         case ($urandom_range(0, 9))
            0: begin
               w_raw = $urandom_range(0, 3);
               h_raw = $urandom_range(0, 16);
            end
            1, 2: begin
               w_raw = $urandom_range(13, 32);
               h_raw = $urandom_range(1, 4);
            end
            default: begin
               w_raw = $urandom_range(1, 12);
               h_raw = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
                                                   : $urandom_range(0, 8);
            end
         endcase
         set_image(CFG_W'(w_raw), CFG_W'(h_raw));
         if ($urandom_range(0, 15) == 0) write_reg(REG_SPARE_LO, CFG_W'($urandom));
         n_frames = $urandom_range(1, 3);
         for (int f = 0; f < n_frames; f++) begin
            if (words_sent - rand_start > RAND_WORDS - CALM_WORDS) begin
               src_idle_on = 1'b0;
               sink_idle_on = 1'b0;
            end else begin
               src_idle_on = $urandom_range(0, 3) != 0;
               sink_idle_on = $urandom_range(0, 3) != 0;
            end
            total = width_now * height_now + width_now + 1;
            send_frame(($urandom_range(0, 7) == 0) ? $urandom_range(1, total - 1) : WHOLE);
         end
      end

      // Wind down: wait for the last results, then a little longer so that a
      // stray extra word would still be caught.
      req_tvalid <= 1'b0;
      for (k = 0; k < DRAIN_MAX && pending_words != 0; k++) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
      if (pending_words != 0) $display("%0d predicted results never came out", pending_words);
      $display("Covered %0d full frames plus cut ones: small random images, the reset size",
               frames_sent);
      $display("and clamped oversize sizes, %0d register writes, %0d words in, %0d checked.",
               writes_done, words_sent, checked_words);
      if (error_count == 0 && pending_words == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Hard stop, several times the slowest correct run.
   initial begin : watchdog
      #6_000_000;
      $display("Timed out with %0d words in and %0d results outstanding",
               words_sent, pending_words);
      $display("TB_ERROR");
      $finish;
   end

endmodule
